// ----- sv/mcof_pkg.sv -----
// ----------------------------------------------------------------------------
// mcof_pkg
// Shared widths, window size and control type of the median clock-offset
// filter.
// ----------------------------------------------------------------------------
package mcof_pkg;

  // window depth, in offset samples
  localparam int WINDOW = 16;

  // ring index and fill count widths
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);

  // payload field widths
  localparam int TS_W   = 48;
  localparam int OFS_W  = 49;
  localparam int HELD_W = 5;

  // stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = ((2 * TS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OFS_W + HELD_W + 7) / 8) * 8;

  // control of the rank counter
  typedef struct packed {
    logic clr;  // start a new candidate
    logic en;   // count one compared sample
  } rank_ctl_t;

endpackage

// ----- sv/median_clock_offset_filter_top.sv -----
// ----------------------------------------------------------------------------
// median_clock_offset_filter_top
// Sliding-window median of remote minus local clock offsets.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sync exchange per beat: local_time and remote_time.
//   The offset remote - local goes into a ring of WINDOW samples; m_axis
//   returns one beat per input: the median of the held samples (upper median
//   on even counts) and the number of samples held.
//   The median is found by rank counting with one comparator: each candidate
//   slot is compared against all n held samples, one per cycle, out of a ring
//   memory with one registered read port. The search stops at the first
//   candidate whose rank is n/2.
//   s_axis_tready is high only while the block is idle; one item is in work
//   at a time. The result sits in an output register, so a new item is taken
//   while the previous result still waits on m_axis; a finished median holds
//   in the block until that register frees up.
//   Reset (rst, synchronous) empties the window and clears both counters;
//   no clearing pass is needed since only filled slots are ever read.
// ----------------------------------------------------------------------------
module median_clock_offset_filter_top
  import mcof_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [47:0] local_time, [95:48] remote_time
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [48:0] median_offset, [53:49] samples_held, rest zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CAND  = 3'd1;
  localparam logic [2:0] S_CWAIT = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_HOLD  = 3'd5;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [IDX_W-1:0] wr_slot;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] cand_idx;
  logic [IDX_W-1:0] scan_idx;
  logic [OFS_W-1:0] cand;
  logic [OFS_W-1:0] median;
  logic [HELD_W-1:0] held;

  logic             in_beat;
  logic             out_free;
  logic [OFS_W-1:0] offset;
  logic [IDX_W-1:0] rd_addr;
  logic [OFS_W-1:0] rd_data;
  logic [CNT_W-1:0] rank;
  rank_ctl_t        rank_ctl;
  logic             scan_last;

  assign s_axis_tready = (state == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // offset of the incoming exchange, exact in 49 bits
  assign offset = {1'b0, s_axis_tdata[2*TS_W-1:TS_W]} -
                  {1'b0, s_axis_tdata[TS_W-1:0]};

  assign scan_last = (CNT_W'(scan_idx) + CNT_W'(1)) == count;

  // read address per sequencer step
  always_comb begin
    case (state)
      S_CAND:  rd_addr = cand_idx;
      S_CWAIT: rd_addr = '0;
      S_SCAN:  rd_addr = scan_idx + IDX_W'(1);
      default: rd_addr = '0;
    endcase
  end

  // rank counter control
  always_comb begin
    rank_ctl.clr = (state == S_CWAIT);
    rank_ctl.en  = (state == S_SCAN);
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_beat) state_next = S_CAND;
      S_CAND:  state_next = S_CWAIT;
      S_CWAIT: state_next = S_SCAN;
      S_SCAN:  if (scan_last) state_next = S_CHECK;
      S_CHECK: state_next = (rank == (count >> 1)) ? S_HOLD : S_CAND;
      S_HOLD:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      wr_slot       <= '0;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // ring pointer and fill count
      if (in_beat) begin
        wr_slot <= (wr_slot == IDX_W'(WINDOW - 1)) ? '0 : wr_slot + IDX_W'(1);
        if (count != CNT_W'(WINDOW)) begin
          count <= count + CNT_W'(1);
        end
      end
      // output valid
      if (state == S_HOLD && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // candidate and scan indexes, result register
  always_ff @(posedge clk) begin
    if (in_beat) begin
      cand_idx <= '0;
    end else if (state == S_CHECK && state_next == S_CAND) begin
      cand_idx <= cand_idx + IDX_W'(1);
    end
    if (state == S_CWAIT) begin
      cand     <= rd_data;
      scan_idx <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (state == S_HOLD && out_free) begin
      median <= cand;
      held   <= HELD_W'(count);
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W - OFS_W - HELD_W){1'b0}}, held, median};

  mcof_ring u_ring (
    .clk     (clk),
    .wr_en   (in_beat),
    .wr_addr (wr_slot),
    .wr_data (offset),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mcof_rank u_rank (
    .clk        (clk),
    .ctl        (rank_ctl),
    .sample     (rd_data),
    .sample_idx (scan_idx),
    .cand       (cand),
    .cand_idx   (cand_idx),
    .rank       (rank)
  );

endmodule

// ----- sv/mcof_ring.sv -----
// ----------------------------------------------------------------------------
// mcof_ring
// Offset sample ring: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mcof_ring
  import mcof_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [OFS_W-1:0] wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [OFS_W-1:0] rd_data
);

  logic [OFS_W-1:0] mem [WINDOW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- sv/mcof_rank.sv -----
// ----------------------------------------------------------------------------
// mcof_rank
// Shared comparator and rank counter: counts samples that sort ahead of the
// current candidate, ties broken by ring slot.
// ----------------------------------------------------------------------------
module mcof_rank
  import mcof_pkg::*;
(
  input  logic             clk,
  input  rank_ctl_t        ctl,
  input  logic [OFS_W-1:0] sample,
  input  logic [IDX_W-1:0] sample_idx,
  input  logic [OFS_W-1:0] cand,
  input  logic [IDX_W-1:0] cand_idx,
  output logic [CNT_W-1:0] rank
);

  logic ahead;

  // signed compare, lower slot wins on equal values
  assign ahead = ($signed(sample) < $signed(cand)) ||
                 ((sample == cand) && (sample_idx < cand_idx));

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      rank <= '0;
    end else if (ctl.en && ahead) begin
      rank <= rank + CNT_W'(1);
    end
  end

endmodule

// ----- test/median_clock_offset_filter_checker.sv -----
// ----------------------------------------------------------------------------
// median_clock_offset_filter_checker
// Watches both stream channels of the median clock-offset filter, keeps its
// own copy of the offset window, predicts the median and fill count for every
// accepted sync exchange and compares each result beat, field by field,
// against the oldest prediction.
// ----------------------------------------------------------------------------
module median_clock_offset_filter_checker
  import mcof_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // [47:0] local_time, [95:48] remote_time
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [48:0] median_offset, [53:49] samples_held, rest zero
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    fail_count,
  output int                    results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [OFS_W-1:0] median_offset;
    logic [HELD_W-1:0]       samples_held;
  } filter_result_t;

  // predicted window state
  logic signed [OFS_W-1:0] offset_window [WINDOW];
  int unsigned             next_slot;
  int unsigned             held_count;
  filter_result_t          median_q [$];
  filter_result_t          oldest;

  initial begin
    fail_count   = 0;
    results_owed = 0;
    next_slot    = 0;
    held_count   = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    fail_count++;
  endtask

  // store one offset, then sort the held samples and take index count/2
  function automatic filter_result_t add_exchange(input logic [TS_W-1:0] local_ts,
                                                  input logic [TS_W-1:0] remote_ts);
    logic signed [OFS_W-1:0] sorted [WINDOW];
    logic signed [OFS_W-1:0] key;
    int                      k;
    int                      m;
    filter_result_t          res;
    offset_window[next_slot] = $signed({1'b0, remote_ts}) - $signed({1'b0, local_ts});
    next_slot = (next_slot + 1) % WINDOW;
    if (held_count < WINDOW) held_count++;
    // insertion sort; equal values keep their order, which cannot change the pick
    for (k = 0; k < held_count; k++) begin
      key = offset_window[k];
      m   = k;
      while (m > 0 && sorted[m-1] > key) begin
        sorted[m] = sorted[m-1];
        m--;
      end
      sorted[m] = key;
    end
    res.median_offset = sorted[held_count / 2];
    res.samples_held  = HELD_W'(held_count);
    return res;
  endfunction

  // result beats first, so a beat never matches an input taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      foreach (offset_window[k]) offset_window[k] = '0;
      next_slot  = 0;
      held_count = 0;
      median_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (median_q.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%0h with nothing expected", m_axis_tdata));
        end else begin
          oldest = median_q.pop_front();
          if (m_axis_tdata[OFS_W-1:0] !== oldest.median_offset)
            report_mismatch($sformatf("median_offset: expected %0d, got %0d",
                                      oldest.median_offset,
                                      $signed(m_axis_tdata[OFS_W-1:0])));
          if (m_axis_tdata[OFS_W +: HELD_W] !== oldest.samples_held)
            report_mismatch($sformatf("samples_held: expected %0d, got %0d",
                                      oldest.samples_held, m_axis_tdata[OFS_W +: HELD_W]));
          if (m_axis_tdata[OUT_DATA_W-1:OFS_W+HELD_W] !== '0)
            report_mismatch($sformatf("padding bits: expected 0, got 0x%0h",
                                      m_axis_tdata[OUT_DATA_W-1:OFS_W+HELD_W]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        median_q.push_back(add_exchange(s_axis_tdata[TS_W-1:0],
                                        s_axis_tdata[2*TS_W-1:TS_W]));
    end
    results_owed = median_q.size();
  end

endmodule

// ----- test/tb_median_clock_offset_filter_top.sv -----
// ----------------------------------------------------------------------------
// tb_median_clock_offset_filter_top
// Drives sync exchanges into the median clock-offset filter: directed
// extremes, ties and a window wrap, then a random mix of drifting clock pairs
// with jitter, repeated offsets and full-range timestamps, with random gaps
// and stalls on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_median_clock_offset_filter_top;
  import mcof_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TS_W-1:0] TS_MAX = '1;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  int                    fail_count;
  int                    results_owed;

  // no gaps or stalls while set
  logic                  quiet = 1'b0;
  int unsigned           rx_wait;
  int unsigned           rx_draw;

  median_clock_offset_filter_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  median_clock_offset_filter_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .results_owed  (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #25_000_000;
    $display("median_clock_offset_filter_top verification failed");
    $finish;
  end

  // result side: after each beat, stall for a random number of cycles
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else if (m_axis_tready) begin
      if (m_axis_tvalid) begin
        if (!quiet) begin
          rx_draw = $urandom_range(0, 10);
          rx_wait <= rx_draw;
          if (rx_draw != 0) m_axis_tready <= 1'b0;
        end
      end
    end else if (rx_wait <= 1) begin
      m_axis_tready <= 1'b1;
      rx_wait       <= 0;
    end else begin
      rx_wait <= rx_wait - 1;
    end
  end

  function automatic logic [TS_W-1:0] rand_ts();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[TS_W-1:0];
  endfunction

  // one exchange beat; valid stays high across back-to-back beats
  task automatic send_exchange(input logic [TS_W-1:0] local_ts,
                               input logic [TS_W-1:0] remote_ts);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {remote_ts, local_ts};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  initial begin
    int          n;
    int unsigned pick;
    int unsigned mag;
    int unsigned k;
    logic [TS_W-1:0] base;
    longint      skew;
    longint      jitter;
    longint      last_offset;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // extremes of both timestamps, alternating bit patterns
    send_exchange('0, '0);
    send_exchange(TS_MAX, '0);
    send_exchange('0, TS_MAX);
    send_exchange(TS_MAX, TS_MAX);
    send_exchange(48'h5555_5555_5555, 48'haaaa_aaaa_aaaa);
    send_exchange(48'haaaa_aaaa_aaaa, 48'h5555_5555_5555);
    // small offsets with ties and both signs, past one full window
    for (n = 0; n < 18; n++)
      send_exchange(TS_W'(5000 + n * 7), TS_W'(5000 + n * 7 + (n % 3) * 4 - 4));

    // random mix
    base        = TS_W'({4'h1, rand_ts()} >> 5);
    skew        = 0;
    last_offset = 0;
    for (n = 0; n < 1400; n++) begin
      if ($urandom_range(0, 79) == 0) quiet <= ~quiet;
      if ($urandom_range(0, 199) == 0)
        skew = $urandom_range(0, 1) ? -longint'($urandom_range(0, 1 << 30))
                                    : longint'($urandom_range(0, 1 << 30));
      pick = $urandom_range(0, 99);
      base = base + $urandom_range(1, 2_000_000);
      if (pick < 55) begin
        // drifting clock pair with jitter of random scale
        k           = $urandom_range(0, 20);
        mag         = $urandom_range(0, 1 << k);
        jitter      = $urandom_range(0, 1) ? -longint'(mag) : longint'(mag);
        last_offset = skew + jitter;
        send_exchange(base, TS_W'(longint'(base) + last_offset));
      end else if (pick < 70) begin
        // same offset as the previous exchange
        send_exchange(base, TS_W'(longint'(base) + last_offset));
      end else begin
        send_exchange(rand_ts(), rand_ts());
      end
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    wait (results_owed == 0);
    repeat (320) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("median_clock_offset_filter_top verification clean");
    end else begin
      $display("median_clock_offset_filter_top verification failed");
    end
    $finish;
  end

endmodule
